>>> rtl/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types, character codes and helpers for the HTTP request line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrlp_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int POS_W        = $clog2(BUFFER_BYTES);
  localparam int OFF_W        = 12;
  localparam int STATUS_W     = 3;
  localparam int VER_W        = 8;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [OFF_W-1:0] off_t;

  localparam pos_t POS_LAST = pos_t'(BUFFER_BYTES - 1);

  // status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_METH  = 3'd1,
    ST_BAD_URI   = 3'd2,
    ST_BAD_PROTO = 3'd3,
    ST_BAD_DIGIT = 3'd4,
    ST_NO_LF     = 3'd5,
    ST_EARLY_END = 3'd6,
    ST_TOO_LONG  = 3'd7
  } status_t;

  typedef enum logic [4:0] {
    PH_G, PH_E, PH_T, PH_SP, PH_SLASH, PH_URI, PH_QUERY,
    PH_H, PH_T1, PH_T2, PH_P, PH_PSLASH,
    PH_MAJ0, PH_MAJ, PH_MIN0, PH_MIN, PH_LF
  } phase_t;

  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // one accepted input beat
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    phase_t           phase;
    pos_t             pos;
    pos_t             uri_begin;
    pos_t             uri_size;
    logic             dot_seen;
    pos_t             dot_pos;
    pos_t             dot_size;
    logic [VER_W-1:0] major;
    logic [VER_W-1:0] minor;
    logic             skip;
  } pstate_t;

  typedef struct packed {
    status_t          status;
    off_t             uri_offset;
    off_t             uri_length;
    logic             has_extension;
    off_t             ext_offset;
    off_t             ext_length;
    logic [VER_W-1:0] version_major;
    logic [VER_W-1:0] version_minor;
    off_t             headers_offset;
  } result_t;

  localparam pstate_t PSTATE_RESET = '{
    phase: PH_G, pos: '0, uri_begin: '0, uri_size: '0, dot_seen: 1'b0,
    dot_pos: '0, dot_size: '0, major: '0, minor: '0, skip: 1'b0
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // v*10 + digit, saturating at 255
  function automatic logic [VER_W-1:0] add_digit(input logic [VER_W-1:0] v,
                                                 input logic [7:0] c);
    logic [11:0] n;
    n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {4'b0000, c - CH_0};
    return (n > 12'd255) ? 8'hff : n[VER_W-1:0];
  endfunction

  // low bits of an offset as shown on the result
  function automatic off_t off12(input logic [POS_W:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[OFF_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/hrlp_in_reg.sv
// ----------------------------------------------------------------------------
// hrlp_in_reg
// Input register: holds one request byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hrlp_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire hrlp_pkg::beat_t in_beat,
  input  wire logic           pop,
  output logic                held_valid,
  output hrlp_pkg::beat_t     held_beat
);
  import hrlp_pkg::*;

  logic take;

  assign in_ready = !held_valid || pop;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (pop) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_beat <= in_beat;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hrlp_fsm.sv
// ----------------------------------------------------------------------------
// hrlp_fsm
// Request line state machine: one byte per step, offsets and version tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module hrlp_fsm (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            beat_valid,
  input  wire hrlp_pkg::beat_t beat,
  input  wire logic            step,
  output logic                 res_valid,
  output hrlp_pkg::result_t    res
);
  import hrlp_pkg::*;

  pstate_t    st;
  pstate_t    st_next;
  pstate_t    upd;
  status_t    err;
  logic       lf_ok;
  logic [7:0] c;
  logic       done;

  assign c = beat.data;

  // byte decode: syntax check and field updates
  always_comb begin
    upd   = st;
    err   = ST_OK;
    lf_ok = 1'b0;
    case (st.phase)
      PH_G:  if (c == CH_G) upd.phase = PH_E; else err = ST_BAD_METH;
      PH_E:  if (c == CH_E) upd.phase = PH_T; else err = ST_BAD_METH;
      PH_T:  if (c == CH_T) upd.phase = PH_SP; else err = ST_BAD_METH;
      PH_SP: if (c == CH_SPACE) upd.phase = PH_SLASH; else err = ST_BAD_METH;
      PH_SLASH: begin
        if (c == CH_SLASH) begin
          upd.uri_begin = st.pos;
          upd.phase     = PH_URI;
        end else begin
          err = ST_BAD_URI;
        end
      end
      PH_URI: begin
        if (c == CH_SPACE || c == CH_QUEST) begin
          upd.uri_size = st.pos - st.uri_begin;
          upd.dot_size = st.dot_seen ? st.pos - st.dot_pos : '0;
          upd.phase    = (c == CH_QUEST) ? PH_QUERY : PH_H;
        end else if (c == CH_DOT) begin
          upd.dot_seen = 1'b1;
          upd.dot_pos  = st.pos + 1'b1;
        end else if (c == CH_SLASH) begin
          upd.dot_seen = 1'b0;
          upd.dot_pos  = '0;
        end
      end
      PH_QUERY: if (c == CH_SPACE) upd.phase = PH_H;
      PH_H:      if (c == CH_H) upd.phase = PH_T1; else err = ST_BAD_PROTO;
      PH_T1:     if (c == CH_T) upd.phase = PH_T2; else err = ST_BAD_PROTO;
      PH_T2:     if (c == CH_T) upd.phase = PH_P; else err = ST_BAD_PROTO;
      PH_P:      if (c == CH_P) upd.phase = PH_PSLASH; else err = ST_BAD_PROTO;
      PH_PSLASH: if (c == CH_SLASH) upd.phase = PH_MAJ0; else err = ST_BAD_PROTO;
      PH_MAJ0: begin
        if (is_digit(c)) begin
          upd.major = c - CH_0;
          upd.phase = PH_MAJ;
        end else begin
          err = ST_BAD_DIGIT;
        end
      end
      PH_MAJ: begin
        if (c == CH_DOT) upd.phase = PH_MIN0;
        else if (is_digit(c)) upd.major = add_digit(st.major, c);
        else err = ST_BAD_DIGIT;
      end
      PH_MIN0: begin
        if (is_digit(c)) begin
          upd.minor = c - CH_0;
          upd.phase = PH_MIN;
        end else begin
          err = ST_BAD_DIGIT;
        end
      end
      PH_MIN: begin
        if (c == CH_CR) upd.phase = PH_LF;
        else if (is_digit(c)) upd.minor = add_digit(st.minor, c);
        else err = ST_BAD_DIGIT;
      end
      PH_LF: if (c == CH_LF) lf_ok = 1'b1; else err = ST_NO_LF;
      default: err = ST_BAD_METH;
    endcase
    if (err == ST_OK) begin
      if (beat.last) err = ST_EARLY_END;
      else if (st.pos == POS_LAST) err = ST_TOO_LONG;
    end
    upd.pos = st.pos + 1'b1;
  end

  assign done = (err != ST_OK) || lf_ok;

  // next state
  always_comb begin
    st_next = st;
    if (step) begin
      if (st.skip) begin
        if (beat.last) st_next = PSTATE_RESET;
      end else if (done) begin
        st_next      = PSTATE_RESET;
        st_next.skip = !beat.last;
      end else begin
        st_next = upd;
      end
    end
  end

  // result
  always_comb begin
    res_valid = beat_valid && !st.skip && done;
    res       = '0;
    res.status = err;
    if (err == ST_OK) begin
      res.uri_offset     = off12({1'b0, st.uri_begin});
      res.uri_length     = off12({1'b0, st.uri_size});
      res.has_extension  = st.dot_seen;
      res.ext_offset     = st.dot_seen ? off12({1'b0, st.dot_pos}) : '0;
      res.ext_length     = st.dot_seen ? off12({1'b0, st.dot_size}) : '0;
      res.version_major  = st.major;
      res.version_minor  = st.minor;
      res.headers_offset = off12({1'b0, st.pos} + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= PSTATE_RESET;
    end else begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hrlp_out_reg.sv
// ----------------------------------------------------------------------------
// hrlp_out_reg
// Result register: holds one parse result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hrlp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire hrlp_pkg::result_t load_res,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hrlp_pkg::result_t      out_res
);
  import hrlp_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule

`default_nettype wire

>>> rtl/http_request_line_parser.sv
// ----------------------------------------------------------------------------
// http_request_line_parser
// Byte-stream parser for a GET request line: URI, extension and version.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | byte_in, end_of_data
//  out     | out_valid / out_ready| status, uri_*, ext_*, version_*, headers_offset
//
//  one byte per clock while no result stalls; byte, then result, each registered
//  the path per step is the state machine decode between input and result regs
//  reset (rst, synchronous) empties both registers and restarts at 'G'
//  a stalled result blocks only bytes that would make another result
// ----------------------------------------------------------------------------
`default_nettype none

module http_request_line_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] byte_in,
  input  wire logic       end_of_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      status,
  output logic [11:0]     uri_offset,
  output logic [11:0]     uri_length,
  output logic            has_extension,
  output logic [11:0]     ext_offset,
  output logic [11:0]     ext_length,
  output logic [7:0]      version_major,
  output logic [7:0]      version_minor,
  output logic [11:0]     headers_offset
);
  import hrlp_pkg::*;

  beat_t   in_beat;
  beat_t   held_beat;
  logic    held_valid;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    free;
  logic    step;

  assign in_beat.data = byte_in;
  assign in_beat.last = end_of_data;

  // a held byte moves on unless it makes a result the output cannot take
  assign step = held_valid && (!res_valid || free);

  hrlp_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .pop        (step),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  hrlp_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (held_valid),
    .beat       (held_beat),
    .step       (step),
    .res_valid  (res_valid),
    .res        (res)
  );

  hrlp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .load_res  (res),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign status         = out_res.status;
  assign uri_offset     = out_res.uri_offset;
  assign uri_length     = out_res.uri_length;
  assign has_extension  = out_res.has_extension;
  assign ext_offset     = out_res.ext_offset;
  assign ext_length     = out_res.ext_length;
  assign version_major  = out_res.version_major;
  assign version_minor  = out_res.version_minor;
  assign headers_offset = out_res.headers_offset;

endmodule

`default_nettype wire

>>> rtl/hrlp_checker.sv
// ----------------------------------------------------------------------------
// hrlp_checker
// Port-level checks on the parser results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hrlp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [11:0] uri_offset,
  input wire logic [11:0] uri_length,
  input wire logic        has_extension,
  input wire logic [11:0] ext_offset,
  input wire logic [11:0] ext_length,
  input wire logic [7:0]  version_major,
  input wire logic [7:0]  version_minor,
  input wire logic [11:0] headers_offset
);
  import hrlp_pkg::*;

  logic is_ok;
  logic [12:0] uri_end;
  logic [12:0] ext_end;

  assign is_ok   = (status == ST_OK);
  assign uri_end = {1'b0, uri_offset} + {1'b0, uri_length};
  assign ext_end = {1'b0, ext_offset} + {1'b0, ext_length};

  // error beats carry nothing but the code
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_ok |-> uri_offset == 12'd0 && uri_length == 12'd0 &&
      !has_extension && ext_offset == 12'd0 && ext_length == 12'd0 &&
      version_major == 8'd0 && version_minor == 8'd0 && headers_offset == 12'd0)
    else $error("error result with nonzero fields");

  a_no_ext: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_extension |-> ext_offset == 12'd0 && ext_length == 12'd0)
    else $error("extension fields set without extension");

  // extension lies inside the uri, and the uri ahead of the line end
  a_ext_in_uri: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_ok && has_extension |->
      ext_offset > uri_offset && ext_end <= uri_end)
    else $error("extension outside uri");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_ok |-> uri_offset >= 12'd4 && uri_length != 12'd0 &&
      {1'b0, headers_offset} >= uri_end + 13'd11)
    else $error("request line offsets out of order");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(headers_offset))
    else $error("stalled result changed");

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (.*);

`default_nettype wire
